FILE: hdl/mec_pkg.sv
// shared types, constants and palette function for the escape-time colour unit
package mec_pkg;

  localparam int MaxIter   = 128;
  localparam int FracBits  = 27;
  localparam int NumCells  = 4;
  localparam int StepW     = 8;
  localparam int ThreshW   = 35;
  localparam int CfgDataW  = 35;
  localparam int CfgIdxW   = 1;

  localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_LIMIT     = 1'b1;

  localparam logic [ThreshW-1:0] THRESH_RESET = ThreshW'(64'd5 << FracBits);
  localparam logic [StepW-1:0]   LIMIT_RESET  = 8'd128;

  typedef struct packed {
    logic signed [31:0] point_real;
    logic signed [31:0] point_imag;
  } in_item_t;

  typedef struct packed {
    logic       escaped;
    logic [6:0] escape_step;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  // token handed from cell to cell
  typedef struct packed {
    logic               busy;
    logic               done;
    logic               hit;
    logic [StepW-1:0]   step;
    logic [StepW-1:0]   limit;
    logic signed [31:0] zr;
    logic signed [31:0] zi;
    logic signed [31:0] cr;
    logic signed [31:0] ci;
  } tok_t;

  function automatic logic [23:0] palette(input logic [6:0] p);
    logic [1:0] seg;
    logic [4:0] k;
    logic [7:0] up, half, down;
    seg  = p[6:5];
    k    = p[4:0];
    up   = {k, 3'b000};
    half = 8'd128 - {1'b0, k, 2'b00};
    down = 8'd255 - {k, 3'b000};
    unique case (seg)
      2'd0:    palette = {up, half, down};
      2'd1:    palette = {8'd255, up, 8'd0};
      2'd2:    palette = {half, 8'd255, up};
      default: palette = {8'd0, down, up};
    endcase
  endfunction

endpackage

FILE: hdl/mec_cell.sv
// one iteration cell: two-stage complex square plus escape test
module mec_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [mec_pkg::ThreshW-1:0]    threshold,
  input  mec_pkg::tok_t                  tok_in,
  output mec_pkg::tok_t                  tok_out
);
  import mec_pkg::*;

  // stage a: products
  tok_t               a_r;
  logic signed [63:0] rr_r, ii_r, ri_r;
  // stage b: new z, squares
  tok_t               b_r;
  tok_t               b_nxt;
  logic signed [63:0] nr2_r, ni2_r;

  logic signed [63:0] sub_s, nre_w, nim_w;
  logic signed [31:0] nre, nim;
  logic [64:0]        mag;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647)       sat32 = 32'sh7fffffff;
    else if (x < -64'sd2147483648) sat32 = 32'sh80000000;
    else                           sat32 = x[31:0];
  endfunction

  always_comb begin
    b_nxt = a_r;
    if (a_r.busy && !a_r.done && (a_r.step < a_r.limit)) begin
      b_nxt.zr = nre;
      b_nxt.zi = nim;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.busy <= 1'b0;
      b_r.busy <= 1'b0;
    end else begin
      a_r  <= tok_in;
      rr_r <= 64'(tok_in.zr) * 64'(tok_in.zr);
      ii_r <= 64'(tok_in.zi) * 64'(tok_in.zi);
      ri_r <= 64'(tok_in.zr) * 64'(tok_in.zi);
      b_r  <= b_nxt;
      nr2_r <= 64'(nre) * 64'(nre);
      ni2_r <= 64'(nim) * 64'(nim);
    end
  end

  // arithmetic shift floors toward minus infinity
  assign sub_s = rr_r - ii_r;
  assign nre_w = (sub_s >>> FracBits) + 64'(a_r.cr);
  assign nim_w = (ri_r >>> (FracBits - 1)) + 64'(a_r.ci);
  assign nre   = sat32(nre_w);
  assign nim   = sat32(nim_w);
  assign mag   = ({1'b0, nr2_r} + {1'b0, ni2_r}) >> FracBits;

  always_comb begin
    tok_out = b_r;
    if (b_r.busy && !b_r.done && (b_r.step < b_r.limit)) begin
      if (mag > 65'(threshold)) begin
        tok_out.done = 1'b1;
        tok_out.hit  = 1'b1;
      end else begin
        tok_out.step = b_r.step + 1'b1;
      end
    end else if (b_r.busy) begin
      tok_out.done = 1'b1;
    end
  end

endmodule

FILE: hdl/mandelbrot_escape_colour_unit.sv
// top level: mandelbrot escape-time colour unit built as a ring of iteration cells
// one point at a time; a point runs round a ring of 4 cells, one iteration per cell
// a finished point laps again while the result register is held
// throughput: next point enters the cycle after the ring empties (one point in the ring)
// reset (synchronous, rst_n low) restores threshold 5.0 and limit 128 and empties the ring
module mandelbrot_escape_colour_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mec_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mec_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [mec_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [mec_pkg::CfgDataW-1:0]  cfg_data
);
  import mec_pkg::*;

  // configuration registers
  logic [ThreshW-1:0] thresh_r;
  logic [StepW-1:0]   limit_r;

  // ring links: link[n] feeds cell n
  tok_t               link   [NumCells+1];
  tok_t               ring_in;
  logic               busy_r;
  logic               inject;
  logic               retire;
  tok_t               head;
  logic [StepW-1:0]   lim_sat;

  out_item_t          out_r;
  logic               out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
      limit_r  <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: thresh_r <= cfg_data;
        REG_LIMIT:     limit_r  <= cfg_data[StepW-1:0];
        default:       ;
      endcase
    end
  end

  // limits above the maximum saturate
  assign lim_sat = (limit_r > StepW'(MaxIter)) ? StepW'(MaxIter) : limit_r;

  // a new point may enter once the ring is free; the result register is separate
  assign in_ready = !busy_r;
  assign inject   = in_valid && in_ready;
  assign head     = link[NumCells];
  // a finished point leaves only when the result register can take it
  assign retire   = head.busy && head.done && (!out_valid_r || out_ready);

  always_comb begin
    ring_in = head;
    if (inject) begin
      ring_in.busy  = 1'b1;
      ring_in.done  = 1'b0;
      ring_in.hit   = 1'b0;
      ring_in.step  = '0;
      ring_in.limit = lim_sat;
      ring_in.zr    = in_data.point_real;
      ring_in.zi    = in_data.point_imag;
      ring_in.cr    = in_data.point_real;
      ring_in.ci    = in_data.point_imag;
    end else if (retire) begin
      // retire the finished point from the ring
      ring_in.busy = 1'b0;
    end
  end

  assign link[0] = ring_in;

  for (genvar n = 0; n < NumCells; n++) begin : g_cell
    mec_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .threshold (thresh_r),
      .tok_in    (link[n]),
      .tok_out   (link[n+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (inject) begin
        busy_r <= 1'b1;
      end else if (retire) begin
        busy_r <= 1'b0;
      end
      if (retire) begin
        out_valid_r       <= 1'b1;
        out_r.escaped     <= head.hit;
        out_r.escape_step <= head.hit ? head.step[6:0] : 7'd0;
        {out_r.red, out_r.green, out_r.blue} <= head.hit ? palette(head.step[6:0]) : 24'd0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
